>>> src/annexb_parameter_set_extractor_assert.svh
// Assertion macros for the checker file of the parameter set extractor.
`ifndef ANNEXB_PARAMETER_SET_EXTRACTOR_ASSERT_SVH
`define ANNEXB_PARAMETER_SET_EXTRACTOR_ASSERT_SVH

// Checks a property on every clock edge outside reset.
`define APSE_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("apse assertion failed");

// Checks that a condition in one cycle implies another in the next cycle.
`define APSE_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("apse assertion failed");

`endif

>>> src/apse_pkg.sv
package apse_pkg;

  localparam int MaxResults = 5;
  localparam int CountW = $clog2(MaxResults + 1);

  localparam logic [0:0] CfgCodecMode   = 1'b0;
  localparam logic [0:0] CfgStartOffset = 1'b1;

  localparam logic [4:0] H264TrigType = 5'd7;
  localparam logic [5:0] H265TrigType = 6'd32;
  localparam logic [1:0] H264UnitsAfter = 2'd2;
  localparam logic [1:0] H265UnitsAfter = 2'd3;
  localparam logic [7:0] StartCodeZero = 8'h00;
  localparam logic [7:0] StartCodeOne  = 8'h01;

  typedef enum logic [1:0] {
    PhaseSeek,
    PhaseScan,
    PhasePass,
    PhaseDone
  } phase_t;

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       last;
    logic       found;
  } result_t;

  typedef result_t [MaxResults-1:0] result_arr_t;

  typedef struct packed {
    logic [3:0][7:0] window;
    logic [2:0]      pending;
    phase_t          phase;
    logic            header_wait;
    logic [1:0]      units_left;
    logic [31:0]     bytes_seen;
  } state_t;

  typedef struct packed {
    logic        codec_mode;
    logic [31:0] start_offset;
  } cfg_t;

endpackage

>>> src/annexb_parameter_set_extractor.sv
// Annex B parameter set extractor.
// The input channel (in_valid, in_ready) takes one stream byte per item with an
// end_of_data flag on the final byte. The output channel (out_valid, out_ready)
// delivers the bytes of the extracted unit group, start codes included, and
// end markers that carry byte_valid low.
// An accepted item is decoded in the same cycle into zero to five results,
// which are held in a result buffer; the first result is offered on the next
// cycle. The buffer drains one result per cycle while out_ready is high.
// A new item is accepted while the last buffered result is being taken, so
// items with one or no result sustain one item per cycle while the receiver
// is ready, and an item with more results holds the input until all are taken.
// When the receiver stalls, the current result holds and the input stalls
// while any result waits.
// The configuration port writes codec_mode (index 0) or start_offset
// (index 1), one per write; write them only while the block is idle.
// Synchronous reset clears the stream state, the buffer pointers and both registers.
module annexb_parameter_set_extractor (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  stream_byte,
  input  logic        end_of_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        byte_valid,
  output logic        group_last,
  output logic        group_found,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import apse_pkg::*;

  cfg_t              cfg;
  state_t            st;
  state_t            st_next;
  result_arr_t       results;
  result_arr_t       result_buf;
  logic [CountW-1:0] result_count;
  logic [CountW-1:0] count;
  logic [CountW-1:0] head;
  logic              take;
  logic              accept;
  result_t           cur;

  apse_step u_step (
    .st           (st),
    .cfg          (cfg),
    .stream_byte  (stream_byte),
    .end_of_data  (end_of_data),
    .st_next      (st_next),
    .results      (results),
    .result_count (result_count)
  );

  assign out_valid = (head != count);
  assign take      = out_valid && out_ready;
  assign in_ready  = !out_valid || (take && (head + CountW'(1) == count));
  assign accept    = in_valid && in_ready;

  assign cur         = (head < CountW'(MaxResults)) ? result_buf[head] : '0;
  assign out_byte    = cur.data;
  assign byte_valid  = cur.valid;
  assign group_last  = cur.last;
  assign group_found = cur.found;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg   <= '0;
      st    <= '0;
      count <= '0;
      head  <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CfgCodecMode:   cfg.codec_mode   <= cfg_data[0];
          CfgStartOffset: cfg.start_offset <= cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        st    <= st_next;
        count <= result_count;
        head  <= '0;
      end else if (take) begin
        head <= head + CountW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result_buf <= results;
    end
  end

endmodule

>>> src/apse_step.sv
module apse_step (
  input  apse_pkg::state_t             st,
  input  apse_pkg::cfg_t               cfg,
  input  logic [7:0]                   stream_byte,
  input  logic                         end_of_data,
  output apse_pkg::state_t             st_next,
  output apse_pkg::result_arr_t        results,
  output logic [apse_pkg::CountW-1:0]  result_count
);
  import apse_pkg::*;

  function automatic result_arr_t put(result_arr_t r, logic [CountW-1:0] idx, result_t e);
    result_arr_t tmp;
    tmp = r;
    if (idx < CountW'(MaxResults)) begin
      tmp[idx] = e;
    end
    return tmp;
  endfunction

  always_comb begin
    state_t            s;
    result_arr_t       res;
    logic [CountW-1:0] n;
    logic [2:0]        p;
    logic              trig;
    result_t           e;
    s    = st;
    res  = '0;
    n    = '0;
    p    = '0;
    trig = 1'b0;
    e    = '0;
    if (s.bytes_seen < cfg.start_offset) begin
      s.bytes_seen = s.bytes_seen + 32'd1;
      if (end_of_data) begin
        e   = '{data: 8'h00, valid: 1'b0, last: 1'b1, found: 1'b0};
        res = put(res, n, e);
        n   = n + CountW'(1);
        s   = '0;
      end
    end else begin
      if (s.phase != PhaseDone) begin
        p = (s.pending > 3'd3) ? 3'd3 : s.pending;
        s.window[p[1:0]] = stream_byte;
        p = p + 3'd1;
        if (s.header_wait) begin
          s.header_wait = 1'b0;
          if (cfg.codec_mode) begin
            trig = (stream_byte[6:1] == H265TrigType);
          end else begin
            trig = (stream_byte[4:0] == H264TrigType);
          end
          if (trig && s.phase == PhaseScan) begin
            s.phase      = PhasePass;
            s.units_left = cfg.codec_mode ? H265UnitsAfter : H264UnitsAfter;
            for (int k = 0; k < 4; k++) begin
              e   = '{data: (k == 3) ? StartCodeOne : StartCodeZero,
                      valid: 1'b1, last: 1'b0, found: 1'b1};
              res = put(res, n, e);
              n   = n + CountW'(1);
            end
          end
        end
        if (p == 3'd4) begin
          if (s.window[0] == StartCodeZero && s.window[1] == StartCodeZero &&
              s.window[2] == StartCodeZero && s.window[3] == StartCodeOne) begin
            p = 3'd0;
            if (s.phase == PhasePass) begin
              if (s.units_left != 2'd0) begin
                s.units_left = s.units_left - 2'd1;
                for (int k = 0; k < 4; k++) begin
                  e   = '{data: (k == 3) ? StartCodeOne : StartCodeZero,
                          valid: 1'b1, last: 1'b0, found: 1'b1};
                  res = put(res, n, e);
                  n   = n + CountW'(1);
                end
              end else begin
                e       = '{data: 8'h00, valid: 1'b0, last: 1'b1, found: 1'b1};
                res     = put(res, n, e);
                n       = n + CountW'(1);
                s.phase = PhaseDone;
              end
            end else begin
              s.phase       = PhaseScan;
              s.header_wait = 1'b1;
            end
          end else begin
            if (s.phase == PhasePass) begin
              e   = '{data: s.window[0], valid: 1'b1, last: 1'b0, found: 1'b1};
              res = put(res, n, e);
              n   = n + CountW'(1);
            end
            s.window[0] = s.window[1];
            s.window[1] = s.window[2];
            s.window[2] = s.window[3];
            s.window[3] = 8'h00;
            p = 3'd3;
          end
        end
        s.pending = p;
      end
      if (end_of_data) begin
        if (s.phase == PhasePass) begin
          for (int k = 0; k < 4; k++) begin
            if (3'(k) < s.pending) begin
              e   = '{data: s.window[k], valid: 1'b1, last: 1'b0, found: 1'b1};
              res = put(res, n, e);
              n   = n + CountW'(1);
            end
          end
          if (n != '0) begin
            res[n - CountW'(1)].last = 1'b1;
          end else begin
            e   = '{data: 8'h00, valid: 1'b0, last: 1'b1, found: 1'b1};
            res = put(res, n, e);
            n   = n + CountW'(1);
          end
        end else if (s.phase != PhaseDone) begin
          e   = '{data: 8'h00, valid: 1'b0, last: 1'b1, found: 1'b0};
          res = put(res, n, e);
          n   = n + CountW'(1);
        end
        s = '0;
      end
    end
    st_next      = s;
    results      = res;
    result_count = n;
  end

endmodule

>>> src/apse_checker.sv
`include "annexb_parameter_set_extractor_assert.svh"

module apse_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_byte,
  input logic        byte_valid,
  input logic        group_last,
  input logic        group_found
);

  logic [10:0] out_payload;

  assign out_payload = {out_byte, byte_valid, group_last, group_found};

  `APSE_ASSERT_NEXT(out_hold, out_valid && !out_ready, out_valid && $stable(out_payload))
  `APSE_ASSERT(out_idle_after_reset, $past(rst) |-> !out_valid)
  `APSE_ASSERT(marker_is_last, out_valid && !byte_valid |-> group_last)
  `APSE_ASSERT(not_found_is_marker, out_valid && !group_found |-> !byte_valid && group_last)
  `APSE_ASSERT(ready_when_drained, !out_valid |-> in_ready)

endmodule

bind annexb_parameter_set_extractor apse_checker u_apse_checker (.*);
